### src/randomized_prim_maze_step_unit_macros.svh
// Assertion helpers for the maze step unit.
`ifndef RANDOMIZED_PRIM_MAZE_STEP_UNIT_MACROS_SVH
`define RANDOMIZED_PRIM_MAZE_STEP_UNIT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define RPM_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RPM_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared types and default sizes of the randomized Prim maze step unit.
// ----------------------------------------------------------------------------
package rpm_pkg;

   localparam int GRID_ROWS_DEF  = 32;
   localparam int GRID_COLS_DEF  = 32;
   localparam int LIST_DEPTH_DEF = 4096;

   localparam int POS_W  = 5;    // row and column field width
   localparam int PICK_W = 12;   // pick field width
   localparam int LEN_W  = 13;   // list length field width

   typedef struct packed {
      logic              kind;
      logic [POS_W-1:0]  seed_row;
      logic [POS_W-1:0]  seed_col;
      logic [PICK_W-1:0] pick;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] picked_row;
      logic [POS_W-1:0] picked_col;
      logic             picked_opened;
      logic             vert_opened;
      logic [POS_W-1:0] vert_row;
      logic             horiz_opened;
      logic [POS_W-1:0] horiz_col;
      logic [LEN_W-1:0] list_length;
      logic             done_res;
   } rsp_type;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

endpackage

### src/rpm_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpm_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface rpm_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/randomized_prim_maze_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// randomized_prim_maze_step_unit
// Randomized Prim maze generator: start and step commands on a grid held in
// on-chip memory, with an ordered wall list.
// ----------------------------------------------------------------------------
//  channel   dir  type       beat
//  req_chan  in   req_type   one start or step command
//  rsp_chan  out  rsp_type   one result per command
//
// Start: the grid memory is cleared one cell per cycle, then the start cell
// is opened and its neighbors are queued.
// Step: a bit-serial modulo of pick by the list length, single-port grid
// reads and writes, then the wall list is shifted down over the entries
// behind the taken one, one entry per cycle.
// Reset clears control state only; the grid is swept at each start command.
// req_chan.ready is high only while idle; a pending result holds in the
// output register until taken, and the next command may enter meanwhile.
// ----------------------------------------------------------------------------
`include "randomized_prim_maze_step_unit_macros.svh"

module randomized_prim_maze_step_unit
   import rpm_pkg::*;
#(
   parameter int GRID_ROWS  = GRID_ROWS_DEF,
   parameter int GRID_COLS  = GRID_COLS_DEF,
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rpm_chan_if.sink   req_chan,
   rpm_chan_if.source rsp_chan
);

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int CW    = $clog2(GRID_COLS);
   localparam int EW    = RW + CW;                  // list entry: {row, col}
   localparam int CLW   = $clog2(CELLS);
   localparam int LW    = $clog2(LIST_DEPTH);
   localparam int CNW   = $clog2(LIST_DEPTH + 1);
   localparam int DCW   = $clog2(PICK_W);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLR, ST_SOPEN, ST_DIV, ST_LRD, ST_ARD, ST_AGET,
      ST_VRD1, ST_VRD2, ST_VDEC, ST_VOPA, ST_HRD1, ST_HRD2, ST_HDEC, ST_HOPA,
      ST_QRD, ST_QCHK, ST_SHINIT, ST_SHIFT, ST_FIN, ST_OUT
   } state_type;

   // grid entry bits
   localparam int WALL_B = 1;
   localparam int VIS_B  = 0;

   // ------------------------------------------------------------------
   // Memories: grid {wall, visited} and ordered wall list
   // ------------------------------------------------------------------
   logic [1:0]    map_mem [CELLS];
   logic [EW-1:0] list_mem [LIST_DEPTH];

   logic           map_we;
   logic [CLW-1:0] map_wa, map_ra;
   logic [1:0]     map_wd, map_rd_ff;
   logic           list_we;
   logic [LW-1:0]  list_wa, list_ra;
   logic [EW-1:0]  list_wd, list_rd_ff;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      map_rd_ff <= map_mem[map_ra];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      list_rd_ff <= list_mem[list_ra];
   end

   function automatic logic [CLW-1:0] cell_of(logic [RW-1:0] r, logic [CW-1:0] c);
      return CLW'(r) * CLW'(GRID_COLS) + CLW'(c);
   endfunction

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   state_type       state_ff, state_in, q_ret_ff, q_ret_in;
   logic [CLW-1:0]  clr_ff, clr_in;
   logic [DCW-1:0]  div_cnt_ff, div_cnt_in;
   logic [PICK_W-1:0] pick_ff, pick_in;
   logic [CNW-1:0]  rem_ff, rem_in;
   logic [CNW-1:0]  count_ff, count_in;
   logic [RW-1:0]   r_ff, r_in, q_r_ff, q_r_in, q_nr_ff, q_nr_in, vrow_ff, vrow_in;
   logic [CW-1:0]   c_ff, c_in, q_c_ff, q_c_in, q_nc_ff, q_nc_in, hcol_ff, hcol_in;
   logic            a_wall_ff, a_wall_in, a_vis_ff, a_vis_in, vis_p_ff, vis_p_in;
   logic [1:0]      q_dir_ff, q_dir_in;
   logic [CNW-1:0]  sh_ptr_ff, sh_ptr_in;
   logic [LW-1:0]   sh_wa_ff, sh_wa_in;
   logic            sh_wv_ff, sh_wv_in;
   logic            popen_ff, popen_in, vopen_ff, vopen_in, hopen_ff, hopen_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [CNW:0]    trial;
   logic            q_ok;
   logic [RW-1:0]   q_nr;
   logic [CW-1:0]   q_nc;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign trial = {rem_ff, pick_ff[PICK_W-1]};

   // neighbor of the queue base in the current direction
   always_comb begin
      q_nr = q_r_ff;
      q_nc = q_c_ff;
      q_ok = 1'b0;
      case (q_dir_ff)
         2'd0: begin q_nr = q_r_ff + RW'(1); q_ok = (q_r_ff != RW'(GRID_ROWS - 1)); end
         2'd1: begin q_nr = q_r_ff - RW'(1); q_ok = (q_r_ff != '0); end
         2'd2: begin q_nc = q_c_ff + CW'(1); q_ok = (q_c_ff != CW'(GRID_COLS - 1)); end
         default: begin q_nc = q_c_ff - CW'(1); q_ok = (q_c_ff != '0); end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      q_ret_in     = q_ret_ff;
      clr_in       = clr_ff;
      div_cnt_in   = div_cnt_ff;
      pick_in      = pick_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      q_r_in       = q_r_ff;
      q_c_in       = q_c_ff;
      q_nr_in      = q_nr_ff;
      q_nc_in      = q_nc_ff;
      q_dir_in     = q_dir_ff;
      vrow_in      = vrow_ff;
      hcol_in      = hcol_ff;
      a_wall_in    = a_wall_ff;
      a_vis_in     = a_vis_ff;
      vis_p_in     = vis_p_ff;
      sh_ptr_in    = sh_ptr_ff;
      sh_wa_in     = sh_wa_ff;
      sh_wv_in     = sh_wv_ff;
      popen_in     = popen_ff;
      vopen_in     = vopen_ff;
      hopen_in     = hopen_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      map_we  = 1'b0;
      map_wa  = cell_of(r_ff, c_ff);
      map_wd  = 2'b00;
      map_ra  = '0;
      list_we = 1'b0;
      list_wa = count_ff[LW-1:0];
      list_wd = {q_nr_ff, q_nc_ff};
      list_ra = rem_ff[LW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               popen_in = 1'b0;
               vopen_in = 1'b0;
               hopen_in = 1'b0;
               vrow_in  = '0;
               hcol_in  = '0;
               r_in     = '0;
               c_in     = '0;
               if (req_chan.payload.kind == KIND_START) begin
                  // saturate the start cell into the grid
                  r_in = (int'(req_chan.payload.seed_row) >= GRID_ROWS) ?
                         RW'(GRID_ROWS - 1) : RW'(req_chan.payload.seed_row);
                  c_in = (int'(req_chan.payload.seed_col) >= GRID_COLS) ?
                         CW'(GRID_COLS - 1) : CW'(req_chan.payload.seed_col);
                  count_in = '0;
                  clr_in   = '0;
                  state_in = ST_CLR;
               end else if (count_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  pick_in    = req_chan.payload.pick;
                  rem_in     = '0;
                  div_cnt_in = '0;
                  state_in   = ST_DIV;
               end
            end
         end
         ST_CLR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            map_wd = 2'b10;
            clr_in = clr_ff + CLW'(1);
            if (clr_ff == CLW'(CELLS - 1)) begin
               state_in = ST_SOPEN;
            end
         end
         ST_SOPEN: begin
            map_we   = 1'b1;
            map_wd   = 2'b01;
            popen_in = 1'b1;
            q_r_in   = r_ff;
            q_c_in   = c_ff;
            q_dir_in = '0;
            q_ret_in = ST_OUT;
            state_in = ST_QRD;
         end
         ST_DIV: begin
            // restoring modulo, one pick bit per cycle, msb first
            if (trial >= {1'b0, count_ff}) begin
               rem_in = CNW'(trial - {1'b0, count_ff});
            end else begin
               rem_in = trial[CNW-1:0];
            end
            pick_in    = {pick_ff[PICK_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(PICK_W - 1)) begin
               state_in = ST_LRD;
            end
         end
         ST_LRD: begin
            list_ra  = rem_ff[LW-1:0];
            state_in = ST_ARD;
         end
         ST_ARD: begin
            r_in     = list_rd_ff[EW-1:CW];
            c_in     = list_rd_ff[CW-1:0];
            map_ra   = cell_of(list_rd_ff[EW-1:CW], list_rd_ff[CW-1:0]);
            state_in = ST_AGET;
         end
         ST_AGET: begin
            a_wall_in = map_rd_ff[WALL_B];
            a_vis_in  = map_rd_ff[VIS_B];
            state_in  = ST_VRD1;
         end
         ST_VRD1: begin
            if (r_ff != '0 && r_ff != RW'(GRID_ROWS - 1)) begin
               map_ra   = cell_of(r_ff + RW'(1), c_ff);
               state_in = ST_VRD2;
            end else begin
               state_in = ST_HRD1;
            end
         end
         ST_VRD2: begin
            vis_p_in = map_rd_ff[VIS_B];
            map_ra   = cell_of(r_ff - RW'(1), c_ff);
            state_in = ST_VDEC;
         end
         ST_VDEC: begin
            state_in = ST_HRD1;
            if (vis_p_ff != map_rd_ff[VIS_B]) begin
               // open the unvisited side
               q_r_in   = vis_p_ff ? r_ff - RW'(1) : r_ff + RW'(1);
               map_we   = 1'b1;
               map_wa   = cell_of(q_r_in, c_ff);
               map_wd   = 2'b01;
               vopen_in = 1'b1;
               vrow_in  = q_r_in;
               popen_in = 1'b1;
               q_c_in   = c_ff;
               q_dir_in = '0;
               q_ret_in = ST_HRD1;
               state_in = ST_VOPA;
            end
         end
         ST_VOPA: begin
            map_we   = 1'b1;
            map_wd   = {1'b0, a_vis_ff};
            state_in = ST_QRD;
         end
         ST_HRD1: begin
            if (c_ff != '0 && c_ff != CW'(GRID_COLS - 1)) begin
               map_ra   = cell_of(r_ff, c_ff + CW'(1));
               state_in = ST_HRD2;
            end else begin
               state_in = ST_SHINIT;
            end
         end
         ST_HRD2: begin
            vis_p_in = map_rd_ff[VIS_B];
            map_ra   = cell_of(r_ff, c_ff - CW'(1));
            state_in = ST_HDEC;
         end
         ST_HDEC: begin
            state_in = ST_SHINIT;
            if (vis_p_ff != map_rd_ff[VIS_B]) begin
               q_c_in   = vis_p_ff ? c_ff - CW'(1) : c_ff + CW'(1);
               map_we   = 1'b1;
               map_wa   = cell_of(r_ff, q_c_in);
               map_wd   = 2'b01;
               hopen_in = 1'b1;
               hcol_in  = q_c_in;
               popen_in = 1'b1;
               q_r_in   = r_ff;
               q_dir_in = '0;
               q_ret_in = ST_SHINIT;
               state_in = ST_HOPA;
            end
         end
         ST_HOPA: begin
            map_we   = 1'b1;
            map_wd   = {1'b0, a_vis_ff};
            state_in = ST_QRD;
         end
         ST_QRD: begin
            if (q_ok) begin
               map_ra   = cell_of(q_nr, q_nc);
               q_nr_in  = q_nr;
               q_nc_in  = q_nc;
               state_in = ST_QCHK;
            end else if (q_dir_ff == 2'd3) begin
               state_in = q_ret_ff;
            end else begin
               q_dir_in = q_dir_ff + 2'd1;
            end
         end
         ST_QCHK: begin
            // append a wall neighbor while the list has room, drop otherwise
            if (map_rd_ff[WALL_B] && count_ff != CNW'(LIST_DEPTH)) begin
               list_we  = 1'b1;
               count_in = count_ff + CNW'(1);
            end
            if (q_dir_ff == 2'd3) begin
               state_in = q_ret_ff;
            end else begin
               q_dir_in = q_dir_ff + 2'd1;
               state_in = ST_QRD;
            end
         end
         ST_SHINIT: begin
            sh_ptr_in = rem_ff + CNW'(1);
            sh_wv_in  = 1'b0;
            state_in  = ST_SHIFT;
         end
         ST_SHIFT: begin
            // read entry i+1 and write it to entry i in the next cycle
            if (sh_wv_ff) begin
               list_we = 1'b1;
               list_wa = sh_wa_ff;
               list_wd = list_rd_ff;
            end
            if (sh_ptr_ff < count_ff) begin
               list_ra   = sh_ptr_ff[LW-1:0];
               sh_wa_in  = LW'(sh_ptr_ff - CNW'(1));
               sh_wv_in  = 1'b1;
               sh_ptr_in = sh_ptr_ff + CNW'(1);
            end else begin
               sh_wv_in = 1'b0;
               if (!sh_wv_ff) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            map_we   = 1'b1;
            map_wd   = {a_wall_ff & ~popen_ff, 1'b1};
            count_in = count_ff - CNW'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in.picked_row    = POS_W'(r_ff);
               rsp_in.picked_col    = POS_W'(c_ff);
               rsp_in.picked_opened = popen_ff;
               rsp_in.vert_opened   = vopen_ff;
               rsp_in.vert_row      = POS_W'(vrow_ff);
               rsp_in.horiz_opened  = hopen_ff;
               rsp_in.horiz_col     = POS_W'(hcol_ff);
               rsp_in.list_length   = LEN_W'(count_ff);
               rsp_in.done_res      = (count_ff == '0);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ret_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sh_wv_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ret_ff     <= q_ret_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sh_wv_ff     <= sh_wv_in;
      end
      clr_ff     <= clr_in;
      div_cnt_ff <= div_cnt_in;
      pick_ff    <= pick_in;
      rem_ff     <= rem_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      q_r_ff     <= q_r_in;
      q_c_ff     <= q_c_in;
      q_nr_ff    <= q_nr_in;
      q_nc_ff    <= q_nc_in;
      q_dir_ff   <= q_dir_in;
      vrow_ff    <= vrow_in;
      hcol_ff    <= hcol_in;
      a_wall_ff  <= a_wall_in;
      a_vis_ff   <= a_vis_in;
      vis_p_ff   <= vis_p_in;
      sh_ptr_ff  <= sh_ptr_in;
      sh_wa_ff   <= sh_wa_in;
      popen_ff   <= popen_in;
      vopen_ff   <= vopen_in;
      hopen_ff   <= hopen_in;
      rsp_ff     <= rsp_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `RPM_ASSERT_RST(a_count_bound, clock, reset, count_ff <= CNW'(LIST_DEPTH), "list count over depth")
   `RPM_ASSERT_RST(a_busy_after_beat, clock, reset, (req_chan.valid && req_chan.ready) |=> !req_chan.ready, "ready held after accepted beat")
   `RPM_ASSERT_RST(a_done_match, clock, reset, rsp_valid_ff |-> (rsp_ff.done_res == (rsp_ff.list_length == '0)), "done disagrees with list length")
   `RPM_ASSERT_RST(a_idle_after_reset, clock, reset, $past(reset) |-> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule
